// ----- sv/fbaa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the antialiasing framebuffer.
// No dependencies; used by fbaa_locate and the top level.
package fbaa_pkg;

  localparam int COORD_W = 12;
  localparam int PROD_W  = COORD_W - 1 + 9;
  localparam int LIN_W   = PROD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } loc_req_t;

  localparam logic [1:0] CMD_FILL = 2'd0;
  localparam logic [1:0] CMD_DRAW = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_AA_ENABLE    = 2'd2;

endpackage

// ----- sv/framebuffer_pixel_antialias_top.sv -----
`timescale 1ns / 1ps
// Antialiasing RGB framebuffer top level: command sequencer around a shared
// address unit and one frame RAM. Uses fbaa_pkg, fbaa_locate, fbaa_ram.
// Steps: read or draw goes through ST_LOC1, ST_LOC2 and ST_USE; draw with antialiasing
//   repeats them for 8 neighbors x 9 store accesses through the address unit;
//   fill does one RAM write per cycle, then strobes done; an unused code is answered from idle.
// One request at a time: busy stays high until the result strobe is issued.
// Reset: a clearing pass writes black to all MAX_PIXELS entries, one per
//   cycle, with busy high; configuration writes are taken meanwhile.
// done marks each result for one cycle; the receiver cannot stall.
module framebuffer_pixel_antialias_top #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd,
  input  logic signed [9:0] x_pos,
  input  logic signed [9:0] y_pos,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              done,
  output logic [7:0]        red_out,
  output logic [7:0]        green_out,
  output logic [7:0]        blue_out,
  output logic              in_range,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int CW = (AW + 1 > fbaa_pkg::LIN_W) ? AW + 1 : fbaa_pkg::LIN_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_LOC1  = 3'd3;
  localparam logic [2:0] ST_LOC2  = 3'd4;
  localparam logic [2:0] ST_USE   = 3'd5;

  localparam logic [1:0] PH_MAIN = 2'd0;
  localparam logic [1:0] PH_NBR  = 2'd1;
  localparam logic [1:0] PH_CTR  = 2'd2;

  logic [2:0]       state;
  logic [1:0]       phase;
  logic [2:0]       kidx;
  logic [2:0]       jidx;
  logic [1:0]       cmd_r;
  fbaa_pkg::coord_t x0;
  fbaa_pkg::coord_t y0;
  logic [23:0]      color;
  logic [8:0]       frame_width;
  logic [8:0]       frame_height;
  logic             aa_en;
  logic [CW-1:0]    pix_count;
  logic [CW-1:0]    pix_count_next;
  logic [17:0]      area;
  logic [CW-1:0]    cnt;
  logic             ok_r;
  logic [AW-1:0]    addr_r;
  logic [10:0]      sum_r;
  logic [10:0]      sum_g;
  logic [10:0]      sum_b;

  fbaa_pkg::loc_req_t req;
  fbaa_pkg::coord_t   dxk;
  fbaa_pkg::coord_t   dyk;
  fbaa_pkg::coord_t   dxj;
  fbaa_pkg::coord_t   dyj;
  logic               loc_ok;
  logic [AW-1:0]      loc_addr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [23:0]        ram_wdata;
  logic [23:0]        ram_rdata;
  logic [23:0]        avg;

  function automatic logic signed [1:0] off_dx(input logic [2:0] i);
    case (i)
      3'd0, 3'd3, 3'd5: off_dx = -2'sd1;
      3'd1, 3'd6:       off_dx = 2'sd0;
      default:          off_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] off_dy(input logic [2:0] i);
    case (i)
      3'd0, 3'd1, 3'd2: off_dy = -2'sd1;
      3'd3, 3'd4:       off_dy = 2'sd0;
      default:          off_dy = 2'sd1;
    endcase
  endfunction

  assign busy = (state != ST_IDLE);
  assign avg  = {sum_r[10:3], sum_g[10:3], sum_b[10:3]};

  assign area = 18'(frame_width) * 18'(frame_height);
  assign pix_count_next = (CW'(area) > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : CW'(area);

  always_comb begin
    dxk = fbaa_pkg::coord_t'(off_dx(kidx));
    dyk = fbaa_pkg::coord_t'(off_dy(kidx));
    dxj = fbaa_pkg::coord_t'(off_dx(jidx));
    dyj = fbaa_pkg::coord_t'(off_dy(jidx));
    req.x = x0;
    req.y = y0;
    case (phase)
      PH_NBR: begin
        req.x = x0 + dxk + dxj;
        req.y = y0 + dyk + dyj;
      end
      PH_CTR: begin
        req.x = x0 + dxk;
        req.y = y0 + dyk;
      end
      default: begin
        req.x = x0;
        req.y = y0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = color;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = '0;
      end
      ST_FILL: begin
        ram_we    = (cnt < pix_count);
        ram_waddr = cnt[AW-1:0];
      end
      ST_USE: begin
        if (phase == PH_MAIN) begin
          ram_we = ok_r && (cmd_r == fbaa_pkg::CMD_DRAW);
        end else if (phase == PH_CTR) begin
          ram_we    = ok_r && (ram_rdata != color);
          ram_wdata = avg;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  fbaa_locate #(
    .AW(AW),
    .CW(CW)
  ) u_locate (
    .clk        (clk),
    .req        (req),
    .frame_width(frame_width),
    .pix_count  (pix_count),
    .ok         (loc_ok),
    .addr       (loc_addr)
  );

  fbaa_ram #(
    .WIDTH(24),
    .DEPTH(MAX_PIXELS)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(loc_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      phase        <= PH_MAIN;
      kidx         <= '0;
      jidx         <= '0;
      cnt          <= '0;
      done         <= 1'b0;
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      aa_en        <= 1'b0;
      pix_count    <= '0;
    end else begin
      done      <= 1'b0;
      pix_count <= pix_count_next;
      if (cfg_we) begin
        case (cfg_index)
          fbaa_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          fbaa_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          fbaa_pkg::REG_AA_ENABLE:    aa_en        <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MAX_PIXELS - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            x0    <= fbaa_pkg::coord_t'(x_pos);
            y0    <= fbaa_pkg::coord_t'(y_pos);
            color <= {red, green, blue};
            cnt   <= '0;
            phase <= PH_MAIN;
            case (cmd)
              fbaa_pkg::CMD_FILL: state <= ST_FILL;
              fbaa_pkg::CMD_DRAW, fbaa_pkg::CMD_READ: state <= ST_LOC1;
              default: begin
                done      <= 1'b1;
                red_out   <= '0;
                green_out <= '0;
                blue_out  <= '0;
                in_range  <= 1'b0;
              end
            endcase
          end
        end
        ST_FILL: begin
          if (cnt < pix_count) begin
            cnt <= cnt + CW'(1);
          end else begin
            done      <= 1'b1;
            red_out   <= '0;
            green_out <= '0;
            blue_out  <= '0;
            in_range  <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_LOC1: state <= ST_LOC2;
        ST_LOC2: begin
          ok_r   <= loc_ok;
          addr_r <= loc_addr;
          state  <= ST_USE;
        end
        ST_USE: begin
          case (phase)
            PH_MAIN: begin
              if (cmd_r == fbaa_pkg::CMD_READ) begin
                done      <= 1'b1;
                red_out   <= ok_r ? ram_rdata[23:16] : 8'd0;
                green_out <= ok_r ? ram_rdata[15:8] : 8'd0;
                blue_out  <= ok_r ? ram_rdata[7:0] : 8'd0;
                in_range  <= ok_r;
                state     <= ST_IDLE;
              end else if (ok_r && aa_en) begin
                phase <= PH_NBR;
                kidx  <= '0;
                jidx  <= '0;
                sum_r <= '0;
                sum_g <= '0;
                sum_b <= '0;
                state <= ST_LOC1;
              end else begin
                done      <= 1'b1;
                red_out   <= '0;
                green_out <= '0;
                blue_out  <= '0;
                in_range  <= ok_r;
                state     <= ST_IDLE;
              end
            end
            PH_NBR: begin
              if (ok_r) begin
                sum_r <= sum_r + 11'(ram_rdata[23:16]);
                sum_g <= sum_g + 11'(ram_rdata[15:8]);
                sum_b <= sum_b + 11'(ram_rdata[7:0]);
              end
              if (jidx == 3'd7) begin
                phase <= PH_CTR;
              end else begin
                jidx <= jidx + 3'd1;
              end
              state <= ST_LOC1;
            end
            PH_CTR: begin
              sum_r <= '0;
              sum_g <= '0;
              sum_b <= '0;
              jidx  <= '0;
              if (kidx == 3'd7) begin
                done      <= 1'b1;
                red_out   <= '0;
                green_out <= '0;
                blue_out  <= '0;
                in_range  <= 1'b1;
                phase     <= PH_MAIN;
                state     <= ST_IDLE;
              end else begin
                kidx  <= kidx + 3'd1;
                phase <= PH_NBR;
                state <= ST_LOC1;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/fbaa_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fbaa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/fbaa_locate.sv -----
`timescale 1ns / 1ps
// Shared address unit: linear index y * width + x, checked for negative coordinates and against the pixel count.
// Product is registered; add and compare follow in the next cycle. Uses fbaa_pkg.
module fbaa_locate #(
  parameter int AW = 16,
  parameter int CW = 21
) (
  input  logic               clk,
  input  fbaa_pkg::loc_req_t req,
  input  logic [8:0]         frame_width,
  input  logic [CW-1:0]      pix_count,
  output logic               ok,
  output logic [AW-1:0]      addr
);

  logic                              neg_r;
  logic [fbaa_pkg::PROD_W-1:0]       prod_r;
  logic [fbaa_pkg::COORD_W-2:0]      x_r;
  logic [fbaa_pkg::LIN_W-1:0]        sum;

  always_ff @(posedge clk) begin
    neg_r  <= req.x[fbaa_pkg::COORD_W-1] | req.y[fbaa_pkg::COORD_W-1];
    prod_r <= fbaa_pkg::PROD_W'(req.y[fbaa_pkg::COORD_W-2:0]) *
              fbaa_pkg::PROD_W'(frame_width);
    x_r    <= req.x[fbaa_pkg::COORD_W-2:0];
  end

  assign sum  = fbaa_pkg::LIN_W'(prod_r) + fbaa_pkg::LIN_W'(x_r);
  assign ok   = !neg_r && (CW'(sum) < pix_count);
  assign addr = sum[AW-1:0];

endmodule

// ----- dv/framebuffer_pixel_antialias_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for framebuffer_pixel_antialias_top: directed and random
// fill/draw/read requests checked against a shadow frame with neighbor smoothing.
// Depends on fbaa_pkg for command and register codes.
module framebuffer_pixel_antialias_top_tb;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]        cmd;
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [23:0]       color;
  } pixel_req_t;

  typedef struct {
    logic [1:0]        cmd;
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [23:0]       color;
    logic              hit;
  } pixel_resp_t;

  class framebuffer_shadow;
    localparam int unsigned DEPTH = 65536;
    logic [23:0]  pixels [DEPTH];
    int unsigned  width;
    int unsigned  height;
    bit           aa_on;
    pixel_resp_t  pending_pixels[$];
    int unsigned  errors;

    function new();
      for (int i = 0; i < DEPTH; i++) pixels[i] = '0;
      width  = 256;
      height = 256;
      aa_on  = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] data);
      case (idx)
        fbaa_pkg::REG_FRAME_WIDTH:  width = data;
        fbaa_pkg::REG_FRAME_HEIGHT: height = data;
        fbaa_pkg::REG_AA_ENABLE:    aa_on = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pixel_count();
      longint p;
      p = longint'(width) * longint'(height);
      return (p > DEPTH) ? DEPTH : int'(p);
    endfunction

    function bit locate_pixel(int x, int y, output int unsigned addr);
      longint a;
      addr = 0;
      if (x < 0 || y < 0) return 1'b0;
      a = longint'(y) * longint'(width) + longint'(x);
      if (a >= longint'(pixel_count())) return 1'b0;
      addr = int'(a);
      return 1'b1;
    endfunction

    function logic [23:0] ring_average(int x, int y);
      int unsigned sum_r, sum_g, sum_b, a;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (dx == 0 && dy == 0) continue;
          if (locate_pixel(x + dx, y + dy, a)) begin
            sum_r += pixels[a][23:16];
            sum_g += pixels[a][15:8];
            sum_b += pixels[a][7:0];
          end
        end
      end
      return {8'(sum_r / 8), 8'(sum_g / 8), 8'(sum_b / 8)};
    endfunction

    function void smooth_ring(int x, int y, logic [23:0] color);
      logic [23:0] avg;
      int unsigned a;
      bit          hit;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (dx == 0 && dy == 0) continue;
          avg = ring_average(x + dx, y + dy);
          hit = locate_pixel(x + dx, y + dy, a);
          if (hit && pixels[a] != color) pixels[a] = avg;
        end
      end
    endfunction

    function void take_request(pixel_req_t q);
      pixel_resp_t e;
      int unsigned a, n;
      int          xs, ys;
      xs      = q.x;
      ys      = q.y;
      e.cmd   = q.cmd;
      e.x     = q.x;
      e.y     = q.y;
      e.color = '0;
      e.hit   = 1'b0;
      case (q.cmd)
        fbaa_pkg::CMD_FILL: begin
          n = pixel_count();
          for (int i = 0; i < n; i++) pixels[i] = q.color;
        end
        fbaa_pkg::CMD_DRAW: begin
          if (locate_pixel(xs, ys, a)) begin
            pixels[a] = q.color;
            if (aa_on) smooth_ring(xs, ys, q.color);
            e.hit = 1'b1;
          end
        end
        fbaa_pkg::CMD_READ: begin
          if (locate_pixel(xs, ys, a)) begin
            e.color = pixels[a];
            e.hit   = 1'b1;
          end
        end
        default: ;
      endcase
      pending_pixels.push_back(e);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void match_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic hit);
      pixel_resp_t e;
      if (pending_pixels.size() == 0) begin
        flag($sformatf("ERROR: unexpected result rgb=%h%h%h in_range=%b", r, g, b, hit));
        return;
      end
      e = pending_pixels.pop_front();
      if ({r, g, b} !== e.color || hit !== e.hit)
        flag($sformatf({"ERROR: cmd=%0d x=%0d y=%0d expected rgb=%h in_range=%b,",
                        " got rgb=%h%h%h in_range=%b"},
                       e.cmd, e.x, e.y, e.color, e.hit, r, g, b, hit));
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = fbaa_pkg::CMD_READ;
  logic signed [9:0] x_pos = '0;
  logic signed [9:0] y_pos = '0;
  logic [7:0]        red = '0;
  logic [7:0]        green = '0;
  logic [7:0]        blue = '0;
  logic              done;
  logic [7:0]        red_out;
  logic [7:0]        green_out;
  logic [7:0]        blue_out;
  logic              in_range;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [8:0]        cfg_data = '0;

  framebuffer_shadow shadow = new();
  int unsigned       cycle_count = 0;

  framebuffer_pixel_antialias_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .x_pos    (x_pos),
    .y_pos    (y_pos),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .done     (done),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out),
    .in_range (in_range),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) shadow.match_pixel(red_out, green_out, blue_out, in_range);
  end

  function automatic pixel_req_t make_req(logic [1:0] c, int x, int y, logic [23:0] color);
    pixel_req_t q;
    q.cmd   = c;
    q.x     = 10'(x);
    q.y     = 10'(y);
    q.color = color;
    return q;
  endfunction

  function automatic logic signed [9:0] pick_coord(int unsigned span);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return 10'(int'($urandom_range(span + 1)) - 1);
    else if (sel < 85) return 10'($urandom_range(511));
    else return 10'($urandom());
  endfunction

  function automatic logic [23:0] pick_color();
    logic [23:0] palette [4];
    palette = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00};
    if ($urandom_range(99) < 35) return palette[$urandom_range(3)];
    return 24'($urandom());
  endfunction

  function automatic pixel_req_t random_req();
    pixel_req_t  q;
    int unsigned sel;
    sel     = $urandom_range(99);
    q.x     = pick_coord(shadow.width);
    q.y     = pick_coord(shadow.height);
    q.color = pick_color();
    if (sel < 3) q.cmd = CMD_NONE;
    else if (sel < 7)
      q.cmd = (shadow.pixel_count() <= 4096) ? fbaa_pkg::CMD_FILL : fbaa_pkg::CMD_READ;
    else if (sel < 52) q.cmd = fbaa_pkg::CMD_DRAW;
    else q.cmd = fbaa_pkg::CMD_READ;
    return q;
  endfunction

  // Hold start and the fields until the request is taken.
  task automatic issue(input pixel_req_t q);
    start <= 1'b1;
    cmd   <= q.cmd;
    x_pos <= q.x;
    y_pos <= q.y;
    red   <= q.color[23:16];
    green <= q.color[15:8];
    blue  <= q.color[7:0];
    do @(posedge clk); while (busy);
    shadow.take_request(q);
  endtask

  task automatic maybe_idle(input int unsigned pct);
    int unsigned n;
    n = 0;
    while (n < 20 && $urandom_range(99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h, input bit aa);
    logic [1:0] idx [3];
    logic [8:0] val [3];
    idx = '{fbaa_pkg::REG_FRAME_WIDTH, fbaa_pkg::REG_FRAME_HEIGHT,
            fbaa_pkg::REG_AA_ENABLE};
    val = '{9'(w), 9'(h), 9'(aa)};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      shadow.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    pixel_req_t  directed [$];
    int unsigned phase_w [10];
    int unsigned phase_h [10];
    bit          phase_aa [10];
    int unsigned w, h, pct, sent;
    bit          aa;

    phase_w  = '{1, 256, 1, 4, 7, 16, 256, 13, 3, 100};
    phase_h  = '{1, 1, 256, 4, 5, 16, 256, 9, 40, 200};
    phase_aa = '{1, 1, 1, 1, 0, 1, 1, 1, 0, 1};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{make_req(fbaa_pkg::CMD_READ, 0, 0, 24'h0),
                 make_req(fbaa_pkg::CMD_FILL, 0, 0, 24'hffffff),
                 make_req(fbaa_pkg::CMD_READ, 255, 255, 24'h0),
                 make_req(fbaa_pkg::CMD_DRAW, 255, 255, 24'hff0000),
                 make_req(fbaa_pkg::CMD_READ, 255, 255, 24'h0),
                 make_req(fbaa_pkg::CMD_DRAW, 300, 0, 24'h0000ff),
                 make_req(fbaa_pkg::CMD_READ, 44, 1, 24'h0),
                 make_req(fbaa_pkg::CMD_DRAW, 511, 511, 24'hffffff),
                 make_req(fbaa_pkg::CMD_READ, -512, -512, 24'h0),
                 make_req(fbaa_pkg::CMD_DRAW, -1, 0, 24'h00ff00),
                 make_req(fbaa_pkg::CMD_READ, 0, -1, 24'h0),
                 make_req(CMD_NONE, 511, -1, 24'hffffff),
                 make_req(fbaa_pkg::CMD_READ, 511, 255, 24'h0)};
    foreach (directed[i]) issue(directed[i]);
    settle();
    write_config(256, 256, 1'b1);

    directed = '{make_req(fbaa_pkg::CMD_DRAW, 0, 0, 24'h00ff00),
                 make_req(fbaa_pkg::CMD_READ, 1, 0, 24'h0),
                 make_req(fbaa_pkg::CMD_READ, 1, 1, 24'h0),
                 make_req(fbaa_pkg::CMD_DRAW, 128, 128, 24'h123456),
                 make_req(fbaa_pkg::CMD_READ, 127, 127, 24'h0),
                 make_req(fbaa_pkg::CMD_DRAW, 255, 255, 24'hffffff),
                 make_req(fbaa_pkg::CMD_READ, 254, 254, 24'h0),
                 make_req(fbaa_pkg::CMD_READ, 255, 254, 24'h0)};
    foreach (directed[i]) issue(directed[i]);

    sent = 0;
    for (int p = 0; p < 14; p++) begin
      if (p < 10) begin
        w  = phase_w[p];
        h  = phase_h[p];
        aa = phase_aa[p];
      end else begin
        w  = $urandom_range(24, 1);
        h  = $urandom_range(24, 1);
        aa = $urandom_range(1);
      end
      settle();
      write_config(w, h, aa);
      for (int k = 0; k < 90; k++) begin
        pct = (sent < 420) ? 11 : (sent < 840) ? 61 : 0;
        issue(random_req());
        sent++;
        if ($urandom_range(199) == 0) settle();
        else maybe_idle(pct);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
    repeat (300) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
